// ===== hdl/wpso_pkg.sv =====
// shared types and constants of the wheel pulse speedometer and odometer
// no dependencies; used by every other file of the block except wpso_mul_unit

package wpso_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CntW    = 6;
  localparam int unsigned RemW    = 64;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CFG_PULSES_PER_METER = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SAMPLE_PERIOD_MS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_START_METERS     = 2'd2;

  localparam logic [7:0]  PPM_RESET    = 8'd29;
  localparam logic [15:0] PERIOD_RESET = 16'd250;

  // 3600 s/h * 1e6 us/s * 100 / 1000 m/km
  localparam logic [31:0] CENTI_KMH_SCALE = 32'd360000000;
  localparam logic [15:0] SPEED_MAX       = 16'hffff;

  // quotient steps: 33 for the odometer divide, 16 for speed
  localparam logic [CntW-1:0] ODO_LAST_STEP = 6'd32;
  localparam logic [CntW-1:0] DIV_LAST_STEP = 6'd15;

  typedef struct packed {
    logic        func;
    logic        pin_level;
    logic [31:0] now_us;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [15:0] speed_centi_kmh;
    logic [31:0] odometer_meters;
    logic [31:0] interval_pulses;
    logic [31:0] interval_us;
  } out_item_t;

  typedef struct packed {
    logic            ge;
    logic [RemW-1:0] diff;
  } sub_res_t;

endpackage

// ===== hdl/wpso_sub_unit.sv =====
// shared compare and subtract unit for both restoring divides and the saturation check
// depends on wpso_pkg

module wpso_sub_unit (
  input  logic [wpso_pkg::RemW-1:0] a_i,
  input  logic [wpso_pkg::RemW-1:0] b_i,
  output wpso_pkg::sub_res_t        res_o
);

  logic [wpso_pkg::RemW:0] full;

  assign full       = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.ge   = ~full[wpso_pkg::RemW];
  assign res_o.diff = full[wpso_pkg::RemW-1:0];

endmodule

// ===== hdl/wpso_mul_unit.sv =====
// shared 32 x 32 multiplier with registered product
// no dependencies; it does not use wpso_pkg

module wpso_mul_unit (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] prod_o
);

  logic [63:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= {32'd0, a_i} * {32'd0, b_i};
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== hdl/wheel_pulse_speed_odometer.sv =====
// wheel pulse speedometer and odometer, top level with sequencer and state
// pin samples and ticks that are not due keep the block idle, ready for the next item
// due tick: input stalls through the 33-step odometer divide, two multiplier passes,
//   the saturation check and, unless speed saturates or the interval is zero, the
//   16-step speed divide on the shared subtract unit, then waits for a free output
// reset: async active low, slots, counters, odometer and output valid cleared, ppm 29, period 250 ms

module wheel_pulse_speed_odometer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  wpso_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output wpso_pkg::out_item_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [wpso_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [31:0]                     cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ODO,
    ST_MULN,
    ST_MULD,
    ST_SAT,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e state_q;

  // configuration
  logic [7:0]  ppm_q;
  logic [15:0] period_q;
  logic [7:0]  ppm_eff;

  // sensor tracking; the current slot takes stamps, the other is the last interval end
  logic        level_high_q;
  logic [31:0] pulse_total_q;
  logic [31:0] cur_stamp_q, cur_cnt_q;
  logic        cur_valid_q;
  logic [31:0] oth_stamp_q, oth_cnt_q;
  logic        oth_valid_q;
  logic [31:0] next_sample_q;

  // odometer
  logic [31:0] meter_q;
  logic [7:0]  meter_rem_q;

  // per-tick work registers
  logic [31:0]               dp_q, dus_q;
  logic [wpso_pkg::RemW-1:0] rem_q, dvs_q;
  logic [32:0]               quot_q;
  logic [wpso_pkg::CntW-1:0] cnt_q;
  logic [15:0]               speed_q;

  logic                out_valid_q;
  wpso_pkg::out_item_t out_data_q;

  logic in_xfer, out_xfer, cfg_xfer;
  logic tick_due;

  logic [wpso_pkg::RemW-1:0] sub_b;
  wpso_pkg::sub_res_t        sub_res;
  logic                      mul_en;
  logic [31:0]               mul_a, mul_b;
  logic [63:0]               prod;

  assign ppm_eff     = (ppm_q == 8'd0) ? 8'd1 : ppm_q;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_xfer    = out_valid_q && !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign tick_due    = (in_data_i.now_ms >= next_sample_q);

  // saturation check compares the numerator against the denominator times 2^16
  always_comb begin
    if (state_q == ST_SAT) begin
      sub_b = {prod[47:0], 16'd0};
    end else begin
      sub_b = dvs_q;
    end
  end

  wpso_sub_unit u_sub (
    .a_i   (rem_q),
    .b_i   (sub_b),
    .res_o (sub_res)
  );

  // first pass scales the pulse count, second forms ppm * interval
  always_comb begin
    mul_en = (state_q == ST_MULN) || (state_q == ST_MULD);
    if (state_q == ST_MULN) begin
      mul_a = wpso_pkg::CENTI_KMH_SCALE;
      mul_b = dp_q;
    end else begin
      mul_a = {24'd0, ppm_eff};
      mul_b = dus_q;
    end
  end

  wpso_mul_unit u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      ppm_q         <= wpso_pkg::PPM_RESET;
      period_q      <= wpso_pkg::PERIOD_RESET;
      level_high_q  <= 1'b0;
      pulse_total_q <= '0;
      cur_stamp_q   <= '0;
      cur_cnt_q     <= '0;
      cur_valid_q   <= 1'b0;
      oth_stamp_q   <= '0;
      oth_cnt_q     <= '0;
      oth_valid_q   <= 1'b0;
      next_sample_q <= '0;
      meter_q       <= '0;
      meter_rem_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (out_xfer) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_xfer) begin
        unique case (cfg_index_i)
          wpso_pkg::CFG_PULSES_PER_METER: ppm_q    <= cfg_data_i[7:0];
          wpso_pkg::CFG_SAMPLE_PERIOD_MS: period_q <= cfg_data_i[15:0];
          wpso_pkg::CFG_START_METERS:     meter_q  <= cfg_data_i;
          default: ;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer && !in_data_i.func) begin
            // falling edge of the sensor counts a pulse
            if (level_high_q && !in_data_i.pin_level) begin
              pulse_total_q <= pulse_total_q + 32'd1;
              cur_stamp_q   <= in_data_i.now_us;
              cur_cnt_q     <= pulse_total_q + 32'd1;
              cur_valid_q   <= 1'b1;
            end
            level_high_q <= in_data_i.pin_level;
          end else if (in_xfer && tick_due) begin
            next_sample_q <= in_data_i.now_ms + {16'd0, period_q};
            dp_q          <= '0;
            dus_q         <= '0;
            rem_q         <= {56'd0, meter_rem_q};
            if (cur_valid_q) begin
              // swap: current becomes the interval end, the emptied slot takes stamps
              oth_stamp_q <= cur_stamp_q;
              oth_cnt_q   <= cur_cnt_q;
              oth_valid_q <= 1'b1;
              cur_stamp_q <= '0;
              cur_cnt_q   <= '0;
              cur_valid_q <= 1'b0;
              if (oth_valid_q) begin
                dp_q  <= cur_cnt_q - oth_cnt_q;
                dus_q <= cur_stamp_q - oth_stamp_q;
                rem_q <= {32'd0, 24'd0, meter_rem_q} + {32'd0, cur_cnt_q - oth_cnt_q};
              end
            end
            dvs_q   <= {24'd0, ppm_eff, 32'd0};
            quot_q  <= '0;
            cnt_q   <= wpso_pkg::ODO_LAST_STEP;
            state_q <= ST_ODO;
          end
        end

        ST_ODO: begin
          if (sub_res.ge) begin
            rem_q <= sub_res.diff;
          end
          quot_q <= {quot_q[31:0], sub_res.ge};
          dvs_q  <= {1'b0, dvs_q[wpso_pkg::RemW-1:1]};
          cnt_q  <= cnt_q - 6'd1;
          if (cnt_q == '0) begin
            meter_q     <= meter_q + {quot_q[30:0], sub_res.ge};
            meter_rem_q <= sub_res.ge ? sub_res.diff[7:0] : rem_q[7:0];
            state_q     <= ST_MULN;
          end
        end

        ST_MULN: begin
          state_q <= ST_MULD;
        end

        ST_MULD: begin
          rem_q   <= prod;
          state_q <= ST_SAT;
        end

        ST_SAT: begin
          if (dus_q == '0) begin
            speed_q <= '0;
            state_q <= ST_DONE;
          end else if (sub_res.ge) begin
            speed_q <= wpso_pkg::SPEED_MAX;
            state_q <= ST_DONE;
          end else begin
            dvs_q   <= {prod[48:0], 15'd0};
            quot_q  <= '0;
            cnt_q   <= wpso_pkg::DIV_LAST_STEP;
            state_q <= ST_DIV;
          end
        end

        ST_DIV: begin
          if (sub_res.ge) begin
            rem_q <= sub_res.diff;
          end
          quot_q <= {quot_q[31:0], sub_res.ge};
          dvs_q  <= {1'b0, dvs_q[wpso_pkg::RemW-1:1]};
          cnt_q  <= cnt_q - 6'd1;
          if (cnt_q == '0) begin
            speed_q <= {quot_q[14:0], sub_res.ge};
            state_q <= ST_DONE;
          end
        end

        ST_DONE: begin
          // wait for the output register to free up
          if (!out_valid_q || !out_stall_i) begin
            out_data_q.speed_centi_kmh <= speed_q;
            out_data_q.odometer_meters <= meter_q;
            out_data_q.interval_pulses <= dp_q;
            out_data_q.interval_us     <= dus_q;
            out_valid_q                <= 1'b1;
            state_q                    <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  // restoring divide invariant: partial remainder stays below twice the divisor
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ODO || state_q == ST_DIV) |-> (rem_q < {dvs_q[62:0], 1'b0}))
    else $error("partial remainder out of range");

  // odometer remainder ends below the effective pulses per meter
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MULN) |-> ({24'd0, meter_rem_q} < {24'd0, ppm_eff}))
    else $error("odometer remainder not reduced");

  // zero interval time gives zero speed
  a_zero_interval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.interval_us == '0) |-> (out_data_o.speed_centi_kmh == '0))
    else $error("speed nonzero on zero interval");

  // a result is only loaded while the output register is free or draining
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_q && out_stall_i) |=> (state_q == ST_DONE))
    else $error("result left done state while output blocked");
`endif

endmodule

// ===== verif/wheel_reading_checker.sv =====
// checker for the wheel pulse speedometer and odometer: watches all three channels,
// predicts every reading and compares all its fields; depends on wpso_pkg only

module wheel_reading_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  wpso_pkg::in_item_t             in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  wpso_pkg::out_item_t            out_data_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [wpso_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             readings_o
);

  localparam logic FUNC_PIN = 1'b0;

  // shadow of the block's registers and state
  logic [7:0]  ppm_q;
  logic [15:0] period_q;
  logic        level_q;
  logic        slot_q;
  logic [31:0] pulse_total_q;
  logic [31:0] stamp_us_q [2];
  logic [31:0] stamp_cnt_q [2];
  logic        stamp_ok_q [2];
  logic [31:0] next_ms_q;
  logic [31:0] meters_q;
  logic [7:0]  rem_q;

  wpso_pkg::out_item_t readings_q [$];
  wpso_pkg::out_item_t want;
  int                  fails;
  int                  seen;

  task automatic take_wheel_item(input wpso_pkg::in_item_t it);
    wpso_pkg::out_item_t rd;
    logic [31:0] d_pulses;
    logic [31:0] d_us;
    logic [31:0] last_us;
    logic [31:0] last_cnt;
    logic        last_ok;
    logic        cur;
    logic        oth;
    logic [63:0] ppm_w;
    logic [63:0] sum;
    logic [63:0] speed;
    if (it.func == FUNC_PIN) begin
      // falling edge counts a pulse and stamps the current slot
      if (level_q && !it.pin_level) begin
        pulse_total_q = pulse_total_q + 32'd1;
        stamp_us_q[slot_q]  = it.now_us;
        stamp_cnt_q[slot_q] = pulse_total_q;
        stamp_ok_q[slot_q]  = 1'b1;
      end
      level_q = it.pin_level;
    end else if (it.now_ms >= next_ms_q) begin
      next_ms_q = it.now_ms + 32'(period_q);
      d_pulses  = '0;
      d_us      = '0;
      cur       = slot_q;
      oth       = ~slot_q;
      ppm_w     = (ppm_q == 8'd0) ? 64'd1 : 64'(ppm_q);
      if (stamp_ok_q[cur]) begin
        last_ok  = stamp_ok_q[oth];
        last_us  = stamp_us_q[oth];
        last_cnt = stamp_cnt_q[oth];
        stamp_us_q[oth]  = '0;
        stamp_cnt_q[oth] = '0;
        stamp_ok_q[oth]  = 1'b0;
        slot_q = oth;
        if (last_ok) begin
          d_us     = stamp_us_q[cur] - last_us;
          d_pulses = stamp_cnt_q[cur] - last_cnt;
        end
      end
      sum      = 64'(rem_q) + 64'(d_pulses);
      meters_q = meters_q + 32'(sum / ppm_w);
      rem_q    = 8'(sum % ppm_w);
      speed    = '0;
      if (d_us != 32'd0) begin
        speed = (64'(wpso_pkg::CENTI_KMH_SCALE) * 64'(d_pulses)) / (ppm_w * 64'(d_us));
        if (speed > 64'(wpso_pkg::SPEED_MAX)) speed = 64'(wpso_pkg::SPEED_MAX);
      end
      rd.speed_centi_kmh = speed[15:0];
      rd.odometer_meters = meters_q;
      rd.interval_pulses = d_pulses;
      rd.interval_us     = d_us;
      readings_q.push_back(rd);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppm_q         = wpso_pkg::PPM_RESET;
      period_q      = wpso_pkg::PERIOD_RESET;
      level_q       = 1'b0;
      slot_q        = 1'b0;
      pulse_total_q = '0;
      for (int i = 0; i < 2; i++) begin
        stamp_us_q[i]  = '0;
        stamp_cnt_q[i] = '0;
        stamp_ok_q[i]  = 1'b0;
      end
      next_ms_q = '0;
      meters_q  = '0;
      rem_q     = '0;
      readings_q.delete();
      fails = 0;
      seen  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        unique case (cfg_index_i)
          wpso_pkg::CFG_PULSES_PER_METER: ppm_q    = cfg_data_i[7:0];
          wpso_pkg::CFG_SAMPLE_PERIOD_MS: period_q = cfg_data_i[15:0];
          wpso_pkg::CFG_START_METERS:     meters_q = cfg_data_i;
          default: ;
        endcase
      end
      // results leave before a new item is taken in the same cycle
      if (out_valid_i && !out_stall_i) begin
        seen++;
        if (readings_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("reading %0d with none expected: speed %0d odo %0d pulses %0d us %0d",
                     seen, out_data_i.speed_centi_kmh, out_data_i.odometer_meters,
                     out_data_i.interval_pulses, out_data_i.interval_us);
        end else begin
          want = readings_q.pop_front();
          if (want.speed_centi_kmh !== out_data_i.speed_centi_kmh ||
              want.odometer_meters !== out_data_i.odometer_meters ||
              want.interval_pulses !== out_data_i.interval_pulses ||
              want.interval_us     !== out_data_i.interval_us) begin
            fails++;
            if (fails <= 10) begin
              $display("reading %0d mismatch (exp/got): speed %0d/%0d odo %0d/%0d",
                       seen, want.speed_centi_kmh, out_data_i.speed_centi_kmh,
                       want.odometer_meters, out_data_i.odometer_meters);
              $display("  pulses %0d/%0d us %0d/%0d",
                       want.interval_pulses, out_data_i.interval_pulses,
                       want.interval_us, out_data_i.interval_us);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) take_wheel_item(in_data_i);
    end
    fail_count_o <= fails;
    pending_o    <= readings_q.size();
    readings_o   <= seen;
  end

endmodule

// ===== verif/tb_wheel_pulse_speed_odometer.sv =====
// testbench top for the wheel pulse speedometer and odometer: drives pin samples,
// speed ticks and register writes; needs wpso_pkg, the block and wheel_reading_checker

module tb_wheel_pulse_speed_odometer;

  localparam logic FUNC_PIN       = 1'b0;
  localparam logic FUNC_TICK      = 1'b1;
  localparam int   DRAIN_CYCLES   = 64;
  localparam int   HOLD_CYCLES    = 400;   // long receiver hold-off
  localparam int   WATCHDOG_LIMIT = 4000;  // cycles without any transfer
  localparam int   PHASE_ITEMS    = 160;
  localparam int   ITEMS_TARGET   = 950;

  logic                         clk;
  logic                         rst_n     = 1'b0;
  logic                         in_valid  = 1'b0;
  logic                         in_stall;
  wpso_pkg::in_item_t           in_data   = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  wpso_pkg::out_item_t          out_data;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [wpso_pkg::CfgIdxW-1:0] cfg_index = wpso_pkg::CFG_PULSES_PER_METER;
  logic [31:0]                  cfg_data  = '0;

  int fail_count;
  int pending;
  int readings;

  // stimulus-side bookkeeping
  bit          idle_on   = 1'b1;     // sender gaps enabled
  bit          stall_on  = 1'b1;     // receiver stalls enabled
  int          hold_req  = 0;        // bumped to ask for one long hold-off
  logic        pin_lvl   = 1'b0;     // last level sent on the pin
  logic [31:0] tick_due_at = '0;     // first tick time that evaluates
  logic [15:0] period_set  = wpso_pkg::PERIOD_RESET;
  logic [31:0] us_now      = '0;
  int          items_sent  = 0;
  int          state_items = 0;      // transfers that change the block's state
  int          settings_used = 1;

  wheel_pulse_speed_odometer u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  wheel_reading_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .readings_o   (readings)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // sender gap length: mostly back to back, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (!idle_on || r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(15, 80);
  endfunction

  // one input transfer; valid stays high when the next item follows at once
  task automatic send_item(input wpso_pkg::in_item_t it);
    int gap;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_pin(input logic level, input logic [31:0] us);
    wpso_pkg::in_item_t it;
    it.func      = FUNC_PIN;
    it.pin_level = level;
    it.now_us    = us;
    it.now_ms    = $urandom();   // unused on a pin sample
    if (level != pin_lvl) state_items++;
    pin_lvl = level;
    send_item(it);
  endtask

  task automatic send_tick(input logic [31:0] ms);
    wpso_pkg::in_item_t it;
    it.func      = FUNC_TICK;
    it.pin_level = 1'($urandom_range(1));
    it.now_us    = $urandom();   // unused on a tick
    it.now_ms    = ms;
    // track when the block will evaluate next, so most ticks can be made due
    if (ms >= tick_due_at) begin
      tick_due_at = ms + 32'(period_set);
      state_items++;
    end
    send_item(it);
  endtask

  // one wheel pulse: rise at a random time, fall at the given time
  task automatic pulse(input logic [31:0] us);
    send_pin(1'b1, $urandom());
    send_pin(1'b0, us);
    us_now = us;
  endtask

  task automatic cfg_transfer(input logic [wpso_pkg::CfgIdxW-1:0] idx,
                              input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // unused upper data bits carry junk; the block keeps only the register width
  task automatic write_settings(input logic [7:0] ppm, input logic [15:0] period,
                                input bit load, input logic [31:0] start);
    cfg_transfer(wpso_pkg::CFG_PULSES_PER_METER, {24'($urandom()), ppm});
    cfg_transfer(wpso_pkg::CFG_SAMPLE_PERIOD_MS, {16'($urandom()), period});
    if (load) cfg_transfer(wpso_pkg::CFG_START_METERS, start);
    cfg_valid  <= 1'b0;
    period_set = period;
    settings_used++;
  endtask

  // no input offered until every reading is back and a not-due tick has drained
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver: random stall stretches, or one long hold-off on request
  initial begin
    int stretch;
    int served;
    int r;
    stretch = 0;
    served  = 0;
    forever begin
      @(posedge clk);
      if (served != hold_req) begin
        served = hold_req;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        stretch = 0;
      end else if (!stall_on) begin
        out_stall <= 1'b0;
        stretch = 0;
      end else if (stretch > 0) begin
        stretch--;
      end else begin
        r = $urandom_range(99);
        if (r < 70) begin
          out_stall <= 1'b0;
        end else if (r < 95) begin
          out_stall <= 1'b1;
          stretch = $urandom_range(0, 3);
        end else begin
          out_stall <= 1'b1;
          stretch = $urandom_range(20, 100);
        end
      end
    end
  end

  // watchdog: ends the run when no transfer happens for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    int          r;
    int          phase;
    int          phase_start;
    bit          hold_done;
    logic [32:0] due_sum;
    logic [7:0]  ppm;
    logic [15:0] period;
    bit          load;
    logic [31:0] start;
    int          us_step_max;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset settings: 29 pulses per meter, 250 ms period
    send_tick(32'd0);             // due at once, current slot still empty
    send_tick(32'd100);           // not yet due
    pulse(32'd1000);
    send_tick(32'd250);           // other slot empty: swap, zero interval
    pulse(32'd1000);
    send_tick(32'd500);           // both stamps at the same time: speed zero
    pulse(32'hffff_ff00);
    pulse(32'h0000_0100);
    send_tick(32'd750);           // microsecond time wrapped between stamps
    pulse(32'h0000_0101);
    send_tick(32'd1000);          // one microsecond apart: speed saturates
    send_tick(32'hffff_ffff);     // latest tick time; next due time wraps

    // widest settings, odometer loaded just below its wrap
    wait_idle();
    write_settings(8'd255, 16'hffff, 1'b1, 32'hffff_fffe);
    pulse(us_now + 32'd5000);
    pulse(us_now + 32'd5000);
    send_tick(tick_due_at);       // leaves a remainder above the next setting

    // smaller pulses per meter: remainder and new pulses divided together,
    // odometer wraps
    wait_idle();
    write_settings(8'd2, 16'd1, 1'b0, '0);
    pulse(us_now + 32'd5000);
    pulse(us_now + 32'd5000);
    send_tick(tick_due_at);

    // random part: phases of different settings, mostly well-formed traffic
    phase     = 0;
    hold_done = 1'b0;
    while (items_sent < ITEMS_TARGET) begin
      wait_idle();
      unique case (phase)
        0: begin ppm = 8'd1;   period = 16'd1;    load = 1'b1; start = '0; end
        1: begin ppm = 8'd255; period = 16'hffff; load = 1'b1; start = 32'hffff_ffff; end
        2: begin
          ppm = 8'($urandom_range(1, 255)); period = 16'($urandom_range(1, 1000));
          load = 1'b0; start = '0;
        end
        3: begin
          // zero pulses per meter acts as one
          ppm = 8'd0; period = 16'($urandom_range(1, 1000)); load = 1'b1; start = $urandom();
        end
        default: begin
          ppm = 8'($urandom_range(1, 255)); period = 16'($urandom_range(1, 2000));
          load = 1'($urandom_range(1)); start = $urandom();
        end
      endcase
      write_settings(ppm, period, load, start);
      // every third phase runs with no idling on either side
      idle_on     = (phase % 3 != 1);
      stall_on    = idle_on;
      us_step_max = $urandom_range(20, 200000);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS && items_sent < ITEMS_TARGET) begin
        // one long hold-off while the sender keeps offering items
        if (phase == 2 && !hold_done && items_sent - phase_start >= 40) begin
          hold_req++;
          hold_done = 1'b1;
        end
        r = $urandom_range(99);
        if (r < 62) begin
          // next edge of the wheel signal, rarely at the same microsecond
          if ($urandom_range(49) != 0) us_now = us_now + 32'($urandom_range(1, us_step_max));
          send_pin(~pin_lvl, us_now);
        end else if (r < 80) begin
          due_sum = {1'b0, tick_due_at} + 33'($urandom_range(0, 40));
          send_tick(due_sum[32] ? tick_due_at : due_sum[31:0]);
        end else if (r < 88) begin
          if (tick_due_at != 32'd0) send_tick($urandom_range(tick_due_at - 32'd1, 0));
          else send_tick(tick_due_at);
        end else if (r < 95) begin
          send_pin(pin_lvl, $urandom());          // same level again, ignored
        end else if ($urandom_range(1)) begin
          send_tick($urandom());
        end else begin
          send_pin(1'($urandom_range(1)), $urandom());
        end
      end
      phase++;
    end

    wait_idle();
    $display("covered %0d input transfers (%0d changing state), %0d readings checked",
             items_sent, state_items, readings);
    $display("over %0d register settings including a long receiver hold-off", settings_used);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
